/* sv/wcee_pkg.sv */
// Package: shared types, constants and byte-mapping functions for the escape encoder.
`default_nettype none

package wcee_pkg;

   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 2;

   localparam logic [UNIT_W-1:0]  SHIFT_BASE = 16'hE000;
   localparam logic [UNIT_W-1:0]  SHIFT_LOW  = 16'h0100;
   localparam logic [UNIT_W-1:0]  SHIFT_HIGH = 16'h0A00;
   localparam logic [BYTE_W-1:0]  ESC_BASE   = 8'h10;
   localparam logic [BYTE_W-1:0]  LOW_ADJ    = 8'd14;
   localparam logic [BYTE_W-1:0]  HIGH_ADJ   = 8'd9;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
   localparam logic [COUNT_W-1:0] COUNT_ESC  = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0]  third_byte;
      logic [BYTE_W-1:0]  second_byte;
      logic [BYTE_W-1:0]  first_byte;
      logic [COUNT_W-1:0] byte_count;
   } result_type;

   // Byte values that force an escape adjustment.
   function automatic logic is_special(input logic [BYTE_W-1:0] b);
      logic hit;
      begin
         case (b)
            8'hA4, 8'hA3, 8'hA7, 8'h24, 8'h5B, 8'h00, 8'h5C, 8'h20,
            8'h0D, 8'h0A, 8'h22, 8'h7B, 8'h7D, 8'h40, 8'h80, 8'h7E,
            8'h2F, 8'hBD, 8'h3B, 8'h5D, 8'h5F, 8'h3D, 8'h23: hit = 1'b1;
            default: hit = 1'b0;
         endcase
         return hit;
      end
   endfunction

   // Windows-1252 byte for a code unit, zero when there is none.
   function automatic logic [BYTE_W-1:0] cp1252_byte(input logic [UNIT_W-1:0] u);
      logic [BYTE_W-1:0] w;
      begin
         case (u)
            16'h20AC: w = 8'h80;
            16'h201A: w = 8'h82;
            16'h0192: w = 8'h83;
            16'h201E: w = 8'h84;
            16'h2026: w = 8'h85;
            16'h2020: w = 8'h86;
            16'h2021: w = 8'h87;
            16'h02C6: w = 8'h88;
            16'h2030: w = 8'h89;
            16'h0160: w = 8'h8A;
            16'h2039: w = 8'h8B;
            16'h0152: w = 8'h8C;
            16'h017D: w = 8'h8E;
            16'h2018: w = 8'h91;
            16'h2019: w = 8'h92;
            16'h201C: w = 8'h93;
            16'h201D: w = 8'h94;
            16'h2022: w = 8'h95;
            16'h2013: w = 8'h96;
            16'h2014: w = 8'h97;
            16'h02DC: w = 8'h98;
            16'h2122: w = 8'h99;
            16'h0161: w = 8'h9A;
            16'h203A: w = 8'h9B;
            16'h0153: w = 8'h9C;
            16'h017E: w = 8'h9E;
            16'h0178: w = 8'h9F;
            default:  w = 8'h00;
         endcase
         return w;
      end
   endfunction

endpackage

`default_nettype wire

/* sv/wcee_map.sv */
// Combinational mapping of one code unit to its encoded result.
`default_nettype none

module wcee_map
   import wcee_pkg::*;
(
   input  wire logic [UNIT_W-1:0] code_unit,
   output result_type             result
);

   logic [BYTE_W-1:0] win_byte;
   logic              in_shift;
   logic [UNIT_W-1:0] unit_adj;
   logic [BYTE_W-1:0] hi_byte;
   logic [BYTE_W-1:0] lo_byte;
   logic              hi_spec;
   logic              lo_spec;

   always_comb begin
      win_byte = cp1252_byte(code_unit);
      in_shift = (code_unit > SHIFT_LOW) && (code_unit < SHIFT_HIGH);
      // Range is bounded, so the add never wraps.
      unit_adj = in_shift ? (code_unit + SHIFT_BASE) : code_unit;
      hi_byte  = unit_adj[UNIT_W-1:BYTE_W];
      lo_byte  = unit_adj[BYTE_W-1:0];
      hi_spec  = is_special(hi_byte);
      lo_spec  = is_special(lo_byte);

      result.byte_count  = COUNT_ONE;
      result.first_byte  = '0;
      result.second_byte = '0;
      result.third_byte  = '0;

      if (win_byte != '0) begin
         result.first_byte = win_byte;
      end else if (hi_byte == '0) begin
         result.first_byte = lo_byte;
      end else begin
         result.byte_count  = COUNT_ESC;
         result.first_byte  = ESC_BASE | {6'b0, hi_spec, lo_spec};
         result.second_byte = lo_spec ? (lo_byte + LOW_ADJ) : lo_byte;
         result.third_byte  = hi_spec ? (hi_byte - HIGH_ADJ) : hi_byte;
      end
   end

endmodule

`default_nettype wire

/* sv/wide_char_escape_encoder_top.sv */
// Top level: UCS-2 code unit to escaped byte sequence encoder, stream in, stream out.
//
//   channel | dir | tdata fields (low bit up)                          | beat
//   req_    | in  | code_unit[15:0]                                    | one code unit
//   rsp_    | out | byte_count[1:0], first[9:2], second[17:10], third[25:18] | one result
//
// Two register stages: an input register holds the code unit, the mapping
// logic sits between it and the result register. One beat per cycle while rsp_tready
// stays high; an accepted req is registered in both stages before rsp valid rises.
// Synchronous active-high reset clears both valid flags; payload is not reset.
// Ready flows back through both stages, so each stage refills in the same
// cycle it drains, and a stalled rsp_ side holds up to two beats in flight.
`default_nettype none

module wide_char_escape_encoder_top
   import wcee_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] code_unit

   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata    // [1:0] byte_count, [9:2] first_byte,
                                         // [17:10] second_byte, [25:18] third_byte,
                                         // [31:26] zero
);

   // Input stage
   logic              in_valid_ff;
   logic              in_valid_in;
   logic [UNIT_W-1:0] in_unit_ff;
   logic [UNIT_W-1:0] in_unit_in;

   // Result stage
   logic              out_valid_ff;
   logic              out_valid_in;
   result_type        out_data_ff;
   result_type        out_data_in;

   result_type        map_result;
   logic              out_ready;
   logic              in_ready;

   // Advance the result stage when empty or being drained downstream.
   assign out_ready  = !out_valid_ff || rsp_tready;
   // Advance the input stage when empty or when its beat moves on.
   assign in_ready   = !in_valid_ff || out_ready;
   assign req_tready = in_ready;

   wcee_map u_map (
      .code_unit (in_unit_ff),
      .result    (map_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_unit_in  = in_unit_ff;
      if (in_ready) begin
         in_valid_in = req_tvalid;
         in_unit_in  = req_tdata;
      end

      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_ready) begin
         out_valid_in = in_valid_ff;
         out_data_in  = map_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_unit_ff  <= in_unit_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_data_ff};

endmodule

`default_nettype wire

/* verif/wcee_scoreboard.sv */
// Scoreboard for the escape encoder: predicts each result from the accepted code unit and checks it.
`timescale 1ns / 100ps

module wcee_scoreboard
   import wcee_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,
   output int               mismatch_count,
   output int               outstanding
);

   result_type encoded_q[$];

   // Windows-1252 byte for a code unit, zero when it has none.
   function automatic logic [7:0] win1252_of(input logic [15:0] unit);
      logic [7:0] b;
      case (unit)
         16'h20AC: b = 8'h80;  16'h201A: b = 8'h82;  16'h0192: b = 8'h83;
         16'h201E: b = 8'h84;  16'h2026: b = 8'h85;  16'h2020: b = 8'h86;
         16'h2021: b = 8'h87;  16'h02C6: b = 8'h88;  16'h2030: b = 8'h89;
         16'h0160: b = 8'h8A;  16'h2039: b = 8'h8B;  16'h0152: b = 8'h8C;
         16'h017D: b = 8'h8E;  16'h2018: b = 8'h91;  16'h2019: b = 8'h92;
         16'h201C: b = 8'h93;  16'h201D: b = 8'h94;  16'h2022: b = 8'h95;
         16'h2013: b = 8'h96;  16'h2014: b = 8'h97;  16'h02DC: b = 8'h98;
         16'h2122: b = 8'h99;  16'h0161: b = 8'h9A;  16'h203A: b = 8'h9B;
         16'h0153: b = 8'h9C;  16'h017E: b = 8'h9E;  16'h0178: b = 8'h9F;
         default:  b = 8'h00;
      endcase
      return b;
   endfunction

   // Bytes that collide with script syntax and need an adjusted escape.
   function automatic bit needs_adjust(input logic [7:0] b);
      case (b)
         8'hA4, 8'hA3, 8'hA7, 8'h24, 8'h5B, 8'h00, 8'h5C, 8'h20,
         8'h0D, 8'h0A, 8'h22, 8'h7B, 8'h7D, 8'h40, 8'h80, 8'h7E,
         8'h2F, 8'hBD, 8'h3B, 8'h5D, 8'h5F, 8'h3D, 8'h23: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic result_type encode_unit(input logic [15:0] unit);
      result_type r;
      logic [15:0] u;
      logic [7:0]  hi, lo, win;
      r = '0;
      r.byte_count = COUNT_ONE;
      win = win1252_of(unit);
      if (win != 8'h00) begin
         r.first_byte = win;
         return r;
      end
      u = unit;
      // move the low range up into the private-use area
      if (u > SHIFT_LOW && u < SHIFT_HIGH) begin
         u = u + SHIFT_BASE;
      end
      hi = u[15:8];
      lo = u[7:0];
      if (hi == 8'h00) begin
         r.first_byte = lo;
         return r;
      end
      r.byte_count = COUNT_ESC;
      r.first_byte = ESC_BASE;
      if (needs_adjust(hi)) begin
         r.first_byte = r.first_byte + 8'd2;
         hi = hi - HIGH_ADJ;
      end
      if (needs_adjust(lo)) begin
         r.first_byte = r.first_byte + 8'd1;
         lo = lo + LOW_ADJ;
      end
      r.second_byte = lo;
      r.third_byte  = hi;
      return r;
   endfunction

   task automatic log_error(input string what, input logic [31:0] want, input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t ERROR %s: expected %h, got %h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      result_type want, got;
      if (reset) begin
         encoded_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            encoded_q.push_back(encode_unit(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[25:0]);
            if (encoded_q.size() == 0) begin
               log_error("result beat with nothing pending", 32'h0, rsp_tdata);
            end else begin
               want = encoded_q.pop_front();
               if (got.byte_count !== want.byte_count)
                  log_error("byte_count", 32'(want.byte_count), 32'(got.byte_count));
               if (got.first_byte !== want.first_byte)
                  log_error("first_byte", 32'(want.first_byte), 32'(got.first_byte));
               if (got.second_byte !== want.second_byte)
                  log_error("second_byte", 32'(want.second_byte), 32'(got.second_byte));
               if (got.third_byte !== want.third_byte)
                  log_error("third_byte", 32'(want.third_byte), 32'(got.third_byte));
               if (rsp_tdata[31:26] !== 6'h00)
                  log_error("tdata padding", 32'h0, 32'(rsp_tdata[31:26]));
            end
         end
      end
      outstanding = encoded_q.size();
   end

endmodule

/* verif/tb_wide_char_escape_encoder_top.sv */
// Testbench top for the escape encoder: clock, reset, beat stimulus, back-pressure and verdict.
`timescale 1ns / 100ps

module tb_wide_char_escape_encoder_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 60;

   // code units that map straight to a Windows-1252 byte
   localparam logic [15:0] WIN_UNITS [0:26] = '{
      16'h20AC, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
      16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h017D, 16'h2018,
      16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014, 16'h02DC,
      16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h017E, 16'h0178};

   // byte values that bump the escape byte
   localparam logic [7:0] ADJ_BYTES [0:22] = '{
      8'hA4, 8'hA3, 8'hA7, 8'h24, 8'h5B, 8'h00, 8'h5C, 8'h20, 8'h0D, 8'h0A,
      8'h22, 8'h7B, 8'h7D, 8'h40, 8'h80, 8'h7E, 8'h2F, 8'hBD, 8'h3B, 8'h5D,
      8'h5F, 8'h3D, 8'h23};

   // extremes, range edges and each mapping path
   localparam logic [15:0] EDGE_UNITS [0:23] = '{
      16'h0000, 16'hFFFF, 16'h00FF, 16'h0100, 16'h0101, 16'h09FF, 16'h0A00,
      16'h20AC, 16'h0178, 16'h0192, 16'h2122, 16'h0024, 16'h0124, 16'h0500,
      16'h2424, 16'h2441, 16'h4124, 16'h4141, 16'h8080, 16'hA4A3, 16'h0D00,
      16'h0A0A, 16'hBD5F, 16'h5555};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [15:0] code_unit
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;    // [1:0] byte_count, [9:2] first_byte,
                              // [17:10] second_byte, [25:18] third_byte

   int mismatch_count;
   int outstanding;
   int cycle_count;
   int idle_odds;             // 1-in-N chance of an idle burst; 0 turns idling off
   bit hold_request;          // ask the receiver for one long hold-off
   bit hold_served;

   wide_char_escape_encoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   wcee_scoreboard scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog: bail out if the run hangs.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Receiver: random stall bursts, plus one long hold-off on request so the
   // pipeline fills and backs up into the input.
   initial begin : receiver
      int n;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_served) begin
            rsp_tready <= 1'b0;
            for (n = 0; n < LONG_HOLD; n++) @(negedge clock);
            hold_served = 1'b1;
            rsp_tready <= 1'b1;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Pick a code unit, biased toward the interesting mapping paths.
   function automatic logic [15:0] pick_unit();
      logic [15:0] u;
      case ($urandom_range(0, 6))
         0:       u = WIN_UNITS[$urandom_range(0, 26)];
         1:       u = 16'($urandom_range(32'h0100, 32'h0A00));
         2:       u = {8'h00, 8'($urandom)};
         3:       u = {ADJ_BYTES[$urandom_range(0, 22)], 8'($urandom)};
         4:       u = {8'($urandom), ADJ_BYTES[$urandom_range(0, 22)]};
         5:       u = {ADJ_BYTES[$urandom_range(0, 22)], ADJ_BYTES[$urandom_range(0, 22)]};
         default: u = 16'($urandom);
      endcase
      return u;
   endfunction

   // Offer one beat at the falling edge and hold it until accepted.
   task automatic send_unit(input logic [15:0] unit);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= unit;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         // vary idling every so often, including stretches with none
         if (k % 64 == 0) begin
            case ($urandom_range(0, 2))
               0:       idle_odds = 0;
               1:       idle_odds = 3;
               default: idle_odds = 6;
            endcase
         end
         send_unit(pick_unit());
      end
   endtask

   task automatic wait_drained();
      while (outstanding != 0) @(negedge clock);
   endtask

   initial begin : stimulus
      int k;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 16'h0000;
      idle_odds    = 4;
      hold_request = 1'b0;
      hold_served  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed edges and mapping paths
      for (k = 0; k < 24; k++) send_unit(EDGE_UNITS[k]);

      send_random(300);

      // long receiver hold-off while beats keep coming
      idle_odds    = 0;
      hold_request = 1'b1;
      for (k = 0; k < 20; k++) send_unit(pick_unit());

      // pause the sender until every result is back
      req_tvalid <= 1'b0;
      @(negedge clock);
      wait_drained();

      send_random(400);

      // closing stretch at full rate, no idling on either side
      idle_odds = 0;
      for (k = 0; k < 180; k++) send_unit(pick_unit());

      req_tvalid <= 1'b0;
      @(negedge clock);
      wait_drained();
      repeat (8) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* wide_char_escape_encoder_top.f */
sv/wcee_pkg.sv
sv/wcee_map.sv
sv/wide_char_escape_encoder_top.sv
verif/wcee_scoreboard.sv
verif/tb_wide_char_escape_encoder_top.sv
